[sv/slkp_pkg.sv]
// Shared constants, keyword tables and helper functions for the status line keyword parser.
package slkp_pkg;

   localparam int LINE_BYTES_DEF = 128;

   localparam int KW_COUNT = 9;
   localparam int KW_WORDS = 6;
   localparam int KW_STAT  = 6;
   localparam int KW_OK    = 7;
   localparam int KW_ERROR = 8;
   localparam int KW_SPAN  = 18;

   localparam logic [4:0] POS_BEYOND = 5'd19;
   localparam logic [4:0] WORD_START = 5'd6;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [3:0] KIND_CONNECTED    = 4'd0;
   localparam logic [3:0] KIND_DISCONNECTED = 4'd1;
   localparam logic [3:0] KIND_OTHER_STATUS = 4'd6;
   localparam logic [3:0] KIND_REPLY        = 4'd7;
   localparam logic [3:0] KIND_OTHER        = 4'd8;

   typedef logic [KW_SPAN*8-1:0] kw_row_type;

   // full text of each keyword from line start, zero padded
   localparam kw_row_type KW_ROW [KW_COUNT] = '{
      {"+STAT:CONNECTED", 24'h0},
      {"+STAT:DISCONNECTED"},
      {"+STAT:PLAYING", 40'h0},
      {"+STAT:PAUSED", 48'h0},
      {"+STAT:NEXT", 64'h0},
      {"+STAT:PREV", 64'h0},
      {"+STAT:", 96'h0},
      {"OK", 128'h0},
      {"ERROR", 104'h0}
   };

   // position just past the last character of each keyword
   localparam logic [4:0] KW_END [KW_COUNT] = '{
      5'd15, 5'd18, 5'd13, 5'd12, 5'd10, 5'd10, 5'd6, 5'd2, 5'd5
   };

   // status words must end with the text; prefixes need not
   localparam logic [KW_COUNT-1:0] KW_EXACT = 9'b000111111;

   typedef struct packed {
      logic [3:0] line_kind;
      logic       link_up;
   } result_type;

   function automatic logic [KW_COUNT-1:0] keep_mask(input logic [4:0] pos,
                                                     input logic [7:0] b);
      logic [KW_COUNT-1:0] keep;
      logic [4:0]          idx;
      idx = 5'd17 - pos;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos >= KW_END[k]) begin
            keep[k] = !KW_EXACT[k];
         end else if (KW_EXACT[k] && (pos < WORD_START)) begin
            keep[k] = 1'b1;
         end else begin
            keep[k] = (b == KW_ROW[k][8*idx +: 8]);
         end
      end
      return keep;
   endfunction

   function automatic logic [KW_COUNT-1:0] finish_mask(input logic [4:0] len);
      logic [KW_COUNT-1:0] keep;
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = (KW_END[k] <= len);
      end
      return keep;
   endfunction

endpackage

[sv/slkp_in_stage.sv]
// Input register for received bytes.
module slkp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       s1_valid,
   output logic [7:0] s1_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_ready = !valid_ff || take;
   assign s1_valid  = valid_ff;
   assign s1_byte   = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

[sv/slkp_line_engine.sv]
// Line state, per-position keyword matching and line classification.
module slkp_line_engine #(
   parameter int LINE_BYTES = slkp_pkg::LINE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   input  logic                   out_free,
   output logic                   take,
   output logic                   result_load,
   output slkp_pkg::result_type   result
);

   localparam int HELD_W = $clog2(LINE_BYTES);
   localparam logic [HELD_W-1:0] HELD_LAST = HELD_W'(LINE_BYTES - 1);
   localparam logic [HELD_W-1:0] HELD_BEYOND = HELD_W'(slkp_pkg::POS_BEYOND);

   logic [HELD_W-1:0]             held_ff, held_in;
   logic [slkp_pkg::KW_COUNT-1:0] alive_ff, alive_in;
   logic                          ended_ff, ended_in;
   logic                          fcz_ff, fcz_in;
   logic                          conn_ff, conn_in;

   logic [4:0]                    pos;
   logic                          is_cr, line_end, empty_line, has_result;
   logic [slkp_pkg::KW_COUNT-1:0] alive_fin;
   logic [3:0]                    kind;
   logic                          conn_new;

   always_comb begin
      pos        = (held_ff >= HELD_BEYOND) ? slkp_pkg::POS_BEYOND : held_ff[4:0];
      is_cr      = (in_byte == slkp_pkg::CHAR_CR);
      line_end   = (in_byte == slkp_pkg::CHAR_LF) || (held_ff == HELD_LAST);
      empty_line = (held_ff == '0) || fcz_ff;
      alive_fin  = ended_ff ? alive_ff : (alive_ff & slkp_pkg::finish_mask(pos));

      kind = slkp_pkg::KIND_OTHER_STATUS;
      for (int k = slkp_pkg::KW_WORDS - 1; k >= 0; k--) begin
         if (alive_fin[k]) begin
            kind = 4'(k);
         end
      end
      priority if (alive_fin[slkp_pkg::KW_STAT]) begin
         // kind already holds the status word
      end else if (alive_fin[slkp_pkg::KW_OK] || alive_fin[slkp_pkg::KW_ERROR]) begin
         kind = slkp_pkg::KIND_REPLY;
      end else begin
         kind = slkp_pkg::KIND_OTHER;
      end

      conn_new = conn_ff;
      if (kind == slkp_pkg::KIND_CONNECTED) begin
         conn_new = 1'b1;
      end else if (kind == slkp_pkg::KIND_DISCONNECTED) begin
         conn_new = 1'b0;
      end

      has_result       = in_valid && !is_cr && line_end && !empty_line;
      take             = in_valid && (!has_result || out_free);
      result_load      = take && has_result;
      result.line_kind = kind;
      result.link_up   = conn_new;

      held_in  = held_ff;
      alive_in = alive_ff;
      ended_in = ended_ff;
      fcz_in   = fcz_ff;
      conn_in  = conn_ff;
      if (take && !is_cr) begin
         if (line_end) begin
            held_in  = '0;
            alive_in = '1;
            ended_in = 1'b0;
            fcz_in   = 1'b0;
            if (has_result) begin
               conn_in = conn_new;
            end
         end else begin
            held_in = held_ff + 1'b1;
            if (!ended_ff) begin
               if (in_byte == slkp_pkg::CHAR_NUL) begin
                  alive_in = alive_ff & slkp_pkg::finish_mask(pos);
                  ended_in = 1'b1;
                  fcz_in   = (held_ff == '0);
               end else begin
                  alive_in = alive_ff & slkp_pkg::keep_mask(pos, in_byte);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         alive_ff <= '1;
         ended_ff <= 1'b0;
         fcz_ff   <= 1'b0;
         conn_ff  <= 1'b0;
      end else begin
         held_ff  <= held_in;
         alive_ff <= alive_in;
         ended_ff <= ended_in;
         fcz_ff   <= fcz_in;
         conn_ff  <= conn_in;
      end
   end

endmodule

[sv/slkp_out_stage.sv]
// Result register towards the response channel.
module slkp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  slkp_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_line_kind,
   output logic                 rsp_link_up
);

   logic                 valid_ff, valid_in;
   slkp_pkg::result_type data_ff, data_in;

   assign out_free      = !valid_ff || rsp_ready;
   assign rsp_valid     = valid_ff;
   assign rsp_line_kind = data_ff.line_kind;
   assign rsp_link_up   = data_ff.link_up;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[sv/status_line_keyword_parser.sv]
// Top level of the status line keyword parser.
//
//  channel | ports                               | role
//  req     | req_valid req_ready req_rx_byte     | received bytes, one per word
//  rsp     | rsp_valid rsp_ready rsp_line_kind   | one word per nonempty line
//          | rsp_link_up                         |
//
// One byte a cycle unless a waiting result stalls a line end; a line feed passes
// the input register, then keyword match and classify into the result register.
// Reset clears the line state and the connected flag; no clearing pass.
// A waiting result stalls only a byte that ends a line; other bytes keep flowing.
module status_line_keyword_parser #(
   parameter int LINE_BYTES = slkp_pkg::LINE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_line_kind,
   output logic       rsp_link_up
);

   logic                 take, s1_valid, out_free, result_load;
   logic [7:0]           s1_byte;
   slkp_pkg::result_type result;

   slkp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .s1_valid    (s1_valid),
      .s1_byte     (s1_byte)
   );

   slkp_line_engine #(
      .LINE_BYTES (LINE_BYTES)
   ) u_line_engine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_byte     (s1_byte),
      .out_free    (out_free),
      .take        (take),
      .result_load (result_load),
      .result      (result)
   );

   slkp_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .load          (result_load),
      .result        (result),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_kind (rsp_line_kind),
      .rsp_link_up   (rsp_link_up)
   );

`ifndef ASSERT_OFF
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_kind <= slkp_pkg::KIND_OTHER))
      else $error("line kind out of range");

   a_connected_sets: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_kind == slkp_pkg::KIND_CONNECTED)) |-> rsp_link_up)
      else $error("connected status left flag clear");

   a_disconnected_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_kind == slkp_pkg::KIND_DISCONNECTED)) |-> !rsp_link_up)
      else $error("disconnected status left flag set");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule
